>>> hw/rtl/kce_pkg.sv
// Package: shared types, status codes and FSM states for the kmer coverage estimator.
package kce_pkg;

  localparam int unsigned FB = 16;

  typedef struct packed {
    logic [31:0] row_count;
    logic [31:0] row_frequency;
    logic        last_row;
  } kce_in_t;

  typedef struct packed {
    logic [47:0] coverage;
    logic [47:0] threshold_value;
    logic [63:0] kmers_total;
    logic [63:0] kmers_unique;
    logic [63:0] low_cut_total;
    logic [63:0] low_cut_unique;
    logic [63:0] high_cut_total;
    logic [63:0] high_cut_unique;
    logic [2:0]  status;
  } kce_out_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOFILT   = 3'd1;
  localparam logic [2:0] ST_NOLOW    = 3'd2;
  localparam logic [2:0] ST_NOTINC   = 3'd3;
  localparam logic [2:0] ST_FEW      = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;
  localparam logic [2:0] ST_OVF      = 3'd6;
  localparam logic [2:0] ST_INSUFF   = 3'd7;

  // queue entry from front to back: a row to store, a finish request, or both
  typedef struct packed {
    logic        fin;
    logic        keep;
    logic [31:0] cnt;
    logic [63:0] tot;
    logic [63:0] uni;
    logic [2:0]  err;
  } kce_cmd_t;

  typedef enum logic [4:0] {
    B_IDLE, B_TGT0, B_TGT1, B_SRCH, B_SRCHW, B_SRCHC,
    B_THR0, B_THR1, B_THRM, B_THRD, B_THRE,
    B_SQRT, B_SQRTM, B_CUT, B_CUTW, B_CUTC, B_CUTR, B_CUTS,
    B_CUTM, B_CUTD, B_CUTE, B_COV, B_COVD, B_OUT
  } kce_bstate_t;

endpackage

>>> hw/rtl/kmer_coverage_estimator_top.sv
// Top level: kmer histogram coverage estimator; rows transfer one per cycle while busy is low.
// busy is high while the queue is full or a last row is being processed.
// A last row with an error or fewer than two points goes straight to its result;
// otherwise the back end runs searches, a bit-serial square root and up to six divisions.
// One-cycle result strobe, no receiver stall; sync active-low reset spares the table.
module kmer_coverage_estimator_top #(
  parameter int unsigned TABLE_DEPTH   = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  kce_pkg::kce_in_t in_row,
  output logic             out_strobe,
  output kce_pkg::kce_out_t out_result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [15:0]      cfg_data
);
  import kce_pkg::*;
  logic        take, f_vld, q_vld, q_rd, q_full, b_rdy, fin_r;
  kce_cmd_t    f_cmd, q_cmd;
  logic [15:0] cutoff_r;

  // busy from last row accept until its result
  assign busy = q_full || fin_r;
  assign take = start && !busy;
  // cutoff held steady while a histogram is being finished
  assign cfg_ready = !fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= 16'd64881; fin_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) cutoff_r <= cfg_data;
      if (take && in_row.last_row) fin_r <= 1'b1;
      else if (out_strobe) fin_r <= 1'b0;
    end
  end

  kce_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk(clk), .rst_n(rst_n), .take(take), .row(in_row), .cmd_vld(f_vld), .cmd(f_cmd)
  );

  kce_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr(f_vld), .wd(f_cmd), .full(q_full),
    .rd(q_rd), .vld(q_vld), .rdat(q_cmd)
  );
  assign q_rd = b_rdy && q_vld;

  kce_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_vld(q_vld), .cmd(q_cmd), .cmd_rdy(b_rdy),
    .cutoff(cutoff_r), .res_vld(out_strobe), .res(out_result)
  );

  // result only while a last row is outstanding
  a_res_fin: assert property (@(posedge clk) disable iff (!rst_n) out_strobe |-> fin_r)
    else $error("result without last row");
  // no row taken while queue full
  a_no_ovf: assert property (@(posedge clk) disable iff (!rst_n) q_full |-> !take)
    else $error("row accepted into full queue");
  // busy drops after the result
  a_clear: assert property (@(posedge clk) disable iff (!rst_n) out_strobe |=> !fin_r)
    else $error("busy stuck after result");
endmodule

>>> hw/rtl/kce_divider.sv
// Restoring divider: 128-bit dividend by 64-bit divisor, one quotient bit per cycle.
module kce_divider (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  logic [127:0] num,
  input  logic [63:0]  den,
  output logic         done,
  output logic [63:0]  quo
);
  logic [127:0] n_r, n_nxt;
  logic [63:0]  r_r, r_nxt, q_r, q_nxt;
  logic         over_r, over_nxt, run_r, run_nxt, done_r, done_nxt;
  logic [6:0]   i_r, i_nxt;
  logic [64:0]  sh;

  // one shift-subtract step
  always_comb begin
    n_nxt = n_r; r_nxt = r_r; q_nxt = q_r; over_nxt = over_r;
    run_nxt = run_r; i_nxt = i_r; done_nxt = 1'b0;
    sh = {r_r, n_r[127]};
    if (go) begin
      n_nxt = num; r_nxt = '0; q_nxt = '0; over_nxt = 1'b0;
      run_nxt = 1'b1; i_nxt = 7'd127;
    end else if (run_r) begin
      n_nxt = {n_r[126:0], 1'b0};
      r_nxt = sh[63:0];
      if (sh[64] || sh[63:0] >= den) begin
        r_nxt = sh[63:0] - den;
        if (i_r[6]) over_nxt = 1'b1;
        else q_nxt = q_r | (64'd1 << i_r[5:0]);
      end
      if (i_r == 7'd0) begin
        run_nxt = 1'b0; done_nxt = 1'b1;
      end
      i_nxt = i_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0; done_r <= 1'b0;
    end else begin
      run_r <= run_nxt; done_r <= done_nxt;
    end
    n_r <= n_nxt; r_r <= r_nxt; q_r <= q_nxt; over_r <= over_nxt; i_r <= i_nxt;
  end

  assign done = done_r;
  assign quo  = (den == 64'd0 || over_r) ? '1 : q_r;
endmodule

>>> hw/rtl/kce_front.sv
// Front end: row checks, running totals and error latch; emits commands.
module kce_front #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  kce_pkg::kce_in_t  row,
  output logic              cmd_vld,
  output kce_pkg::kce_cmd_t cmd
);
  import kce_pkg::*;
  localparam int unsigned PW = $clog2(TABLE_DEPTH + 1);

  logic [PW-1:0] pts_r, pts_nxt;
  logic [63:0]   tot_r, tot_nxt, uni_r, uni_nxt, prod, nt, nu;
  logic [32:0]   prev_r, prev_nxt;
  logic [2:0]    err_r, err_nxt;
  logic          keep;

  // combinational product path: one 32x32 multiply, then adds
  always_comb begin
    pts_nxt = pts_r; tot_nxt = tot_r; uni_nxt = uni_r;
    prev_nxt = prev_r; err_nxt = err_r; keep = 1'b0;
    prod = 64'(row.row_count) * 64'(row.row_frequency);
    nt = tot_r + prod;
    nu = uni_r + 64'(row.row_frequency);
    if (take && err_r == ST_OK) begin
      if (!prev_r[32] && {1'b0, row.row_count} <= prev_r) begin
        err_nxt = ST_NOTINC;
      end else begin
        prev_nxt = {1'b0, row.row_count};
        if (row.row_count != 0 && row.row_frequency != 0) begin
          if (pts_r >= PW'(TABLE_DEPTH)) err_nxt = ST_FULL;
          else if (nt < tot_r || nu < uni_r) err_nxt = ST_OVF;
          else begin
            tot_nxt = nt; uni_nxt = nu; pts_nxt = pts_r + 1'b1; keep = 1'b1;
          end
        end
      end
    end
    cmd.fin = take && row.last_row;
    cmd.keep = keep;
    cmd.cnt = row.row_count;
    cmd.tot = cmd.fin ? tot_nxt : nt;
    cmd.uni = cmd.fin ? uni_nxt : nu;
    cmd.err = err_nxt;
    cmd_vld = keep || cmd.fin;
    if (cmd.fin) begin
      pts_nxt = '0; tot_nxt = '0; uni_nxt = '0; prev_nxt = 33'h1_0000_0000; err_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pts_r <= '0; tot_r <= '0; uni_r <= '0; prev_r <= 33'h1_0000_0000; err_r <= ST_OK;
    end else begin
      pts_r <= pts_nxt; tot_r <= tot_nxt; uni_r <= uni_nxt;
      prev_r <= prev_nxt; err_r <= err_nxt;
    end
  end
endmodule

>>> hw/rtl/kce_back.sv
// Back end: table storage, threshold search, interpolation, sqrt and coverage.
module kce_back #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_vld,
  input  kce_pkg::kce_cmd_t cmd,
  output logic              cmd_rdy,
  input  logic [15:0]       cutoff,
  output logic              res_vld,
  output kce_pkg::kce_out_t res
);
  import kce_pkg::*;
  localparam int unsigned FRACTION_BITS = FB;
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned PW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SB = 16 + FRACTION_BITS;
  localparam int unsigned S = FRACTION_BITS - 16;

  // table memory, one row per stored point
  logic [31:0] m_cnt [TABLE_DEPTH];
  logic [63:0] m_tot [TABLE_DEPTH];
  logic [63:0] m_uni [TABLE_DEPTH];
  logic [AW-1:0] ra;
  logic [31:0] rd_cnt;
  logic [63:0] rd_tot, rd_uni;

  kce_bstate_t st_r, st_nxt;
  logic [PW-1:0] n_r, n_nxt, lo_r, lo_nxt, hi_r, hi_nxt, mid;
  logic [63:0] tot_r, tot_nxt, uni_r, uni_nxt, tint_r, tint_nxt;
  logic [15:0] tfrac_r, tfrac_nxt;
  logic [63:0] thr_r, thr_nxt, x_r, x_nxt, s_r, s_nxt;
  logic [5:0]  b_r, b_nxt;
  logic [31:0] c0_r, c0_nxt, c1_r, c1_nxt;
  logic [63:0] t0_r, t0_nxt, t1_r, t1_nxt, u0_r, u0_nxt, u1_r, u1_nxt;
  logic [63:0] lt_r, lt_nxt, lu_r, lu_nxt, ht_r, ht_nxt, hu_r, hu_nxt;
  logic [47:0] cov_r, cov_nxt;
  logic [2:0]  stat_r, stat_nxt;
  logic        pass_r, pass_nxt, tu_r, tu_nxt, low_r, low_nxt;
  logic [127:0] pr_r, pr_nxt;
  logic [63:0]  pa, pb;
  logic [127:0] prod;
  logic [1:0]  ph_r, ph_nxt;
  logic         dgo;
  logic [127:0] dnum_r, dnum_nxt;
  logic [63:0]  dden_r, dden_nxt;
  logic         ddone;
  logic [63:0]  dq;
  logic [31:0]  dc;
  logic [63:0]  dint, qs;

  // dividend is taken on go, divisor is held in dden_r for the whole run
  kce_divider u_div (
    .clk(clk), .rst_n(rst_n), .go(dgo), .num(dnum_nxt), .den(dden_r),
    .done(ddone), .quo(dq)
  );

  // table write on row commands, registered read
  always_ff @(posedge clk) begin
    if (cmd_vld && cmd_rdy && cmd.keep && n_r < PW'(TABLE_DEPTH)) begin
      m_cnt[n_r[AW-1:0]] <= cmd.cnt;
      m_tot[n_r[AW-1:0]] <= cmd.tot;
      m_uni[n_r[AW-1:0]] <= cmd.uni;
    end
    rd_cnt <= m_cnt[ra];
    rd_tot <= m_tot[ra];
    rd_uni <= m_uni[ra];
  end

  // 64x64 product in four 32x32 partials, one per cycle
  always_comb begin
    case (ph_r)
      2'd0: prod = 128'(64'(pa[31:0]) * 64'(pb[31:0]));
      2'd1: prod = 128'(64'(pa[31:0]) * 64'(pb[63:32])) << 32;
      2'd2: prod = 128'(64'(pa[63:32]) * 64'(pb[31:0])) << 32;
      default: prod = 128'(64'(pa[63:32]) * 64'(pb[63:32])) << 64;
    endcase
  end

  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  assign cmd_rdy = (st_r == B_IDLE);
  assign dc = c1_r - c0_r;
  assign dint = tint_r - t0_r;
  // quotient scaled to FRACTION_BITS (saturating)
  always_comb begin
    if (FRACTION_BITS >= 16) qs = (dq > (64'hFFFF_FFFF_FFFF_FFFF >> S)) ? '1 : (dq << S);
    else qs = dq >> (16 - FRACTION_BITS);
  end

  always_comb begin
    st_nxt = st_r; n_nxt = n_r; lo_nxt = lo_r; hi_nxt = hi_r;
    tot_nxt = tot_r; uni_nxt = uni_r; tint_nxt = tint_r; tfrac_nxt = tfrac_r;
    thr_nxt = thr_r; x_nxt = x_r; s_nxt = s_r; b_nxt = b_r;
    c0_nxt = c0_r; c1_nxt = c1_r;
    t0_nxt = t0_r; t1_nxt = t1_r; u0_nxt = u0_r; u1_nxt = u1_r;
    lt_nxt = lt_r; lu_nxt = lu_r; ht_nxt = ht_r; hu_nxt = hu_r;
    cov_nxt = cov_r; stat_nxt = stat_r; pass_nxt = pass_r; tu_nxt = tu_r; low_nxt = low_r;
    pr_nxt = pr_r; ph_nxt = ph_r; dgo = 1'b0; dnum_nxt = dnum_r; dden_nxt = dden_r;
    ra = mid[AW-1:0]; pa = '0; pb = '0; res_vld = 1'b0;
    case (st_r)
      B_IDLE: begin
        if (cmd_vld) begin
          if (cmd.keep) n_nxt = n_r + 1'b1;
          if (cmd.fin) begin
            tot_nxt = cmd.tot; uni_nxt = cmd.uni;
            cov_nxt = '0; thr_nxt = '0; lt_nxt = '0; lu_nxt = '0; ht_nxt = '0; hu_nxt = '0;
            stat_nxt = ST_OK;
            if (cmd.err != ST_OK) begin
              stat_nxt = cmd.err; tot_nxt = '0; uni_nxt = '0; st_nxt = B_OUT;
            end else if (n_nxt < PW'(2)) begin
              stat_nxt = ST_FEW; st_nxt = B_OUT;
            end else st_nxt = B_TGT0;
          end
        end
      end
      // target = cutoff * total in Q.16
      B_TGT0: begin
        pr_nxt = 128'(64'(cutoff) * 64'(tot_r[31:0]));
        st_nxt = B_TGT1;
      end
      B_TGT1: begin
        tint_nxt = ((64'(cutoff) * 64'(tot_r[63:32])) << 16) + (pr_r[63:0] >> 16);
        tfrac_nxt = pr_r[15:0];
        lo_nxt = '0; hi_nxt = n_r; st_nxt = B_SRCH;
      end
      B_SRCH: begin
        if (lo_r < hi_r) st_nxt = B_SRCHW;
        else if (lo_r == '0) begin
          stat_nxt = ST_NOFILT;
          dnum_nxt = {48'd0, tot_r, 16'd0}; dden_nxt = uni_r; dgo = 1'b1;
          st_nxt = B_COVD;
        end else if (lo_r >= n_r) begin
          ra = AW'(n_r - 1'b1); st_nxt = B_THRE;
        end else begin
          ra = lo_r[AW-1:0]; st_nxt = B_THR0;
        end
      end
      B_SRCHW: st_nxt = B_SRCHC;
      B_SRCHC: begin
        if (rd_tot > tint_r) hi_nxt = mid; else lo_nxt = mid + 1'b1;
        st_nxt = B_SRCH;
      end
      B_THRE: begin
        thr_nxt = 64'(rd_cnt) << FRACTION_BITS; st_nxt = B_SQRT;
        s_nxt = '0; b_nxt = 6'(SB - 1);
      end
      B_THR0: begin
        c1_nxt = rd_cnt; t1_nxt = rd_tot; ra = AW'(lo_r - 1'b1); st_nxt = B_THR1;
      end
      B_THR1: begin
        ra = AW'(lo_r - 1'b1); st_nxt = B_THRM;
      end
      B_THRM: begin
        // capture left point on entry then multiply (dint<<16|tfrac) * dc
        if (ph_r == 2'd0 && !pass_r) begin
          c0_nxt = rd_cnt; t0_nxt = rd_tot; pass_nxt = 1'b1; pr_nxt = '0;
        end else begin
          pa = {dint[47:0], tfrac_r}; pb = 64'(dc);
          pr_nxt = pr_r + prod; ph_nxt = ph_r + 1'b1;
          if (ph_r == 2'd3) begin
            pass_nxt = 1'b0;
            dnum_nxt = pr_r + prod + ({64'd0, 64'(dint[63:48]) * 64'(dc)} << 64);
            dden_nxt = t1_r - t0_r; dgo = 1'b1; st_nxt = B_THRD;
          end
        end
      end
      B_THRD: if (ddone) begin
        thr_nxt = (64'(c0_r) << FRACTION_BITS) + qs;
        s_nxt = '0; b_nxt = 6'(SB - 1); st_nxt = B_SQRT;
      end
      // bit-serial square root, one candidate bit per pass through B_SQRT and B_SQRTM
      B_SQRT: begin
        x_nxt = s_r | (64'd1 << b_r); pr_nxt = '0; ph_nxt = '0; st_nxt = B_SQRTM;
      end
      B_SQRTM: begin
        pa = x_r; pb = x_r; pr_nxt = pr_r + prod; ph_nxt = ph_r + 1'b1;
        if (ph_r == 2'd3) begin
          if ((pr_r + prod) <= ({64'd0, thr_r} << FRACTION_BITS)) s_nxt = x_r;
          if (b_r == '0) begin
            x_nxt = (pr_r + prod) <= ({64'd0, thr_r} << FRACTION_BITS) ? x_r : s_r;
            low_nxt = 1'b1; ra = '0; st_nxt = B_CUT;
          end else begin
            b_nxt = b_r - 1'b1; st_nxt = B_SQRT;
          end
        end
      end
      // cut at x_r: range check against first and last counts
      B_CUT: begin ra = '0; st_nxt = B_CUTW; end
      B_CUTW: begin c0_nxt = rd_cnt; ra = AW'(n_r - 1'b1); st_nxt = B_CUTC; end
      B_CUTC: begin
        if (x_r < (64'(c0_r) << FRACTION_BITS) || x_r > (64'(rd_cnt) << FRACTION_BITS)) begin
          if (low_r) begin
            lt_nxt = '0; lu_nxt = '0; stat_nxt = ST_NOLOW;
            low_nxt = 1'b0; x_nxt = thr_r; st_nxt = B_CUT;
          end else begin
            stat_nxt = ST_INSUFF; cov_nxt = '0; st_nxt = B_OUT;
          end
        end else begin
          lo_nxt = PW'(1); hi_nxt = n_r; st_nxt = B_CUTS;
        end
      end
      B_CUTS: begin
        if (lo_r < hi_r) st_nxt = B_CUTR;
        else begin
          if (lo_r >= n_r) lo_nxt = n_r - 1'b1;
          ra = (lo_r >= n_r) ? AW'(n_r - 1'b1) : lo_r[AW-1:0];
          pass_nxt = 1'b0; tu_nxt = 1'b0; st_nxt = B_CUTM; ph_nxt = '0;
        end
      end
      B_CUTR: begin
        st_nxt = B_CUTE;
      end
      B_CUTE: begin
        if ((64'(rd_cnt) << FRACTION_BITS) > x_r) hi_nxt = mid; else lo_nxt = mid + 1'b1;
        st_nxt = B_CUTS;
      end
      B_CUTM: begin
        // take right point, wait for left point, then two mul+div passes
        if (!pass_r) begin
          ra = AW'(lo_r - 1'b1);
          if (ph_r == 2'd0) begin
            c1_nxt = rd_cnt; t1_nxt = rd_tot; u1_nxt = rd_uni; ph_nxt = 2'd1;
          end else if (ph_r == 2'd1) ph_nxt = 2'd2;
          else if (ph_r == 2'd2) ph_nxt = 2'd3;
          else begin
            c0_nxt = rd_cnt; t0_nxt = rd_tot; u0_nxt = rd_uni;
            pass_nxt = 1'b1; ph_nxt = '0; pr_nxt = '0;
          end
        end else begin
          pa = tu_r ? (u1_r - u0_r) : (t1_r - t0_r);
          pb = x_r - (64'(c0_r) << FRACTION_BITS);
          pr_nxt = pr_r + prod; ph_nxt = ph_r + 1'b1;
          if (ph_r == 2'd3) begin
            dnum_nxt = pr_r + prod;
            dden_nxt = 64'(dc) << FRACTION_BITS; dgo = 1'b1; st_nxt = B_CUTD;
          end
        end
      end
      B_CUTD: if (ddone) begin
        if (!tu_r) begin
          if (low_r) lt_nxt = t0_r + dq; else ht_nxt = t0_r + dq;
          tu_nxt = 1'b1; pr_nxt = '0; ph_nxt = '0; st_nxt = B_CUTM;
        end else begin
          pass_nxt = 1'b0; tu_nxt = 1'b0;
          if (low_r) begin
            lu_nxt = u0_r + dq; low_nxt = 1'b0; x_nxt = thr_r; st_nxt = B_CUT;
          end else begin
            hu_nxt = u0_r + dq; st_nxt = B_COV;
          end
        end
      end
      B_COV: begin
        if (hu_r <= lu_r) begin
          stat_nxt = ST_INSUFF; st_nxt = B_OUT;
        end else begin
          dnum_nxt = {48'd0, (ht_r > lt_r) ? ht_r - lt_r : 64'd0, 16'd0};
          dden_nxt = hu_r - lu_r; dgo = 1'b1; st_nxt = B_COVD;
        end
      end
      B_COVD: if (ddone) begin
        cov_nxt = (qs > 64'hFFFF_FFFF_FFFF) ? '1 : qs[47:0];
        st_nxt = B_OUT;
      end
      B_OUT: begin
        res_vld = 1'b1; n_nxt = '0; st_nxt = B_IDLE;
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE; n_r <= '0; ph_r <= '0; pass_r <= 1'b0;
    end else begin
      st_r <= st_nxt; n_r <= n_nxt; ph_r <= ph_nxt; pass_r <= pass_nxt;
    end
    lo_r <= lo_nxt; hi_r <= hi_nxt; tot_r <= tot_nxt; uni_r <= uni_nxt;
    tint_r <= tint_nxt; tfrac_r <= tfrac_nxt; thr_r <= thr_nxt; x_r <= x_nxt;
    s_r <= s_nxt; b_r <= b_nxt; c0_r <= c0_nxt; c1_r <= c1_nxt;
    t0_r <= t0_nxt; t1_r <= t1_nxt; u0_r <= u0_nxt; u1_r <= u1_nxt;
    lt_r <= lt_nxt; lu_r <= lu_nxt; ht_r <= ht_nxt; hu_r <= hu_nxt;
    cov_r <= cov_nxt; stat_r <= stat_nxt; tu_r <= tu_nxt; low_r <= low_nxt;
    pr_r <= pr_nxt; dnum_r <= dnum_nxt; dden_r <= dden_nxt;
  end

  assign res.coverage        = cov_r;
  assign res.threshold_value = thr_r[47:0];
  assign res.kmers_total     = tot_r;
  assign res.kmers_unique    = uni_r;
  assign res.low_cut_total   = lt_r;
  assign res.low_cut_unique  = lu_r;
  assign res.high_cut_total  = ht_r;
  assign res.high_cut_unique = hu_r;
  assign res.status          = stat_r;
endmodule

>>> hw/rtl/kce_fifo.sv
// Short command queue between front and back end.
module kce_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr,
  input  kce_pkg::kce_cmd_t wd,
  output logic              full,
  input  logic              rd,
  output logic              vld,
  output kce_pkg::kce_cmd_t rdat
);
  import kce_pkg::*;
  kce_cmd_t q_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign full = cnt_r == 3'd4;
  assign vld  = cnt_r != 3'd0;
  assign rdat = q_r[rp_r];

  // storage and pointers
  always_ff @(posedge clk) begin
    if (wr) q_r[wp_r] <= wd;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd && vld) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 3'(wr) - 3'(rd && vld);
    end
  end
endmodule

>>> bench/kce_checker.sv
// Checker: watches the row, result and register channels, predicts each result and compares.
module kce_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  kce_pkg::kce_in_t    in_row,
  input  logic                out_strobe,
  input  kce_pkg::kce_out_t   out_result,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [15:0]         cfg_data,
  output int                  fail_count,
  output int                  pending
);
  import kce_pkg::*;

  localparam int unsigned DEPTH = 256;

  typedef logic [63:0] field_set_t [9];

  // predicted histogram state
  logic [31:0]  pt_count  [DEPTH];
  logic [63:0]  pt_total  [DEPTH];
  logic [63:0]  pt_unique [DEPTH];
  int unsigned  npts;
  logic [63:0]  sum_total, sum_unique;
  logic [32:0]  last_cnt;
  logic [2:0]   err_latch;
  logic [15:0]  cutoff;

  kce_out_t     coverage_q[$];
  kce_out_t     exp_res;
  field_set_t   exp_f, got_f;
  string        field_name [9] = '{"coverage", "threshold_value", "kmers_total",
                                   "kmers_unique", "low_cut_total", "low_cut_unique",
                                   "high_cut_total", "high_cut_unique", "status"};

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic field_set_t unpack_fields(input kce_out_t v);
    field_set_t f;
    f[0] = v.coverage;       f[1] = v.threshold_value;
    f[2] = v.kmers_total;    f[3] = v.kmers_unique;
    f[4] = v.low_cut_total;  f[5] = v.low_cut_unique;
    f[6] = v.high_cut_total; f[7] = v.high_cut_unique;
    f[8] = v.status;
    return f;
  endfunction

  // floor(n/d), saturating to 64 bits; zero divisor gives all ones
  function automatic logic [63:0] sat_div(input logic [127:0] n, input logic [63:0] d);
    logic [127:0] q;
    if (d == 0) return '1;
    q = n / {64'd0, d};
    return (q[127:64] != 0) ? '1 : q[63:0];
  endfunction

  // floor square root, Q.16 in and out
  function automatic logic [63:0] root_q(input logic [63:0] x);
    logic [127:0] v;
    logic [63:0]  s, t;
    v = {48'd0, x, 16'd0};
    s = 0;
    for (int b = 31; b >= 0; b--) begin
      t = s | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= v) s = t;
    end
    return s;
  endfunction

  // linear interpolation of the cumulative sums at Q.16 count x; 1 = outside table
  function automatic bit interp_at(input logic [63:0] x, output logic [63:0] tot,
                                   output logic [63:0] uni);
    int unsigned lo, hi, mid;
    logic [31:0] dc;
    logic [63:0] den, dx, dt;
    tot = 0;
    uni = 0;
    if (x < {16'd0, pt_count[0], 16'd0} || x > {16'd0, pt_count[npts-1], 16'd0})
      return 1;
    lo = 1;
    hi = npts;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if ({16'd0, pt_count[mid], 16'd0} > x) hi = mid;
      else lo = mid + 1;
    end
    // search past the last point falls back to the last segment
    if (lo >= npts) lo = npts - 1;
    dc  = pt_count[lo] - pt_count[lo-1];
    den = {16'd0, dc, 16'd0};
    dx  = x - {16'd0, pt_count[lo-1], 16'd0};
    dt  = pt_total[lo] - pt_total[lo-1];
    tot = pt_total[lo-1] + sat_div({64'd0, dt} * {64'd0, dx}, den);
    dt  = pt_unique[lo] - pt_unique[lo-1];
    uni = pt_unique[lo-1] + sat_div({64'd0, dt} * {64'd0, dx}, den);
    return 0;
  endfunction

  function automatic void row_absorb(input logic [31:0] cnt, input logic [31:0] freq);
    logic [63:0] nt, nu;
    if (err_latch != 0) return;
    if (!last_cnt[32] && {1'b0, cnt} <= last_cnt) begin
      err_latch = ST_NOTINC;
      return;
    end
    last_cnt = {1'b0, cnt};
    if (cnt == 0 || freq == 0) return;
    if (npts >= DEPTH) begin
      err_latch = ST_FULL;
      return;
    end
    nt = sum_total + {32'd0, cnt} * {32'd0, freq};
    nu = sum_unique + {32'd0, freq};
    if (nt < sum_total || nu < sum_unique) begin
      err_latch = ST_OVF;
      return;
    end
    sum_total       = nt;
    sum_unique      = nu;
    pt_count[npts]  = cnt;
    pt_total[npts]  = nt;
    pt_unique[npts] = nu;
    npts++;
  endfunction

  function automatic kce_out_t coverage_predict();
    kce_out_t    r;
    logic [79:0] prod;
    logic [63:0] tint, thr, dint, lt, lu, ht, hu, diff, cov;
    logic [15:0] tfrac;
    logic [31:0] dc;
    logic [127:0] num;
    int unsigned left, right, mid;
    r = '0;
    if (err_latch != 0) begin
      r.status = err_latch;
      return r;
    end
    r.kmers_total  = sum_total;
    r.kmers_unique = sum_unique;
    if (npts < 2) begin
      r.status = ST_FEW;
      return r;
    end
    // target = cutoff * total, kept with 16 fraction bits
    prod  = {64'd0, cutoff} * {16'd0, sum_total};
    tint  = prod[79:16];
    tfrac = prod[15:0];
    left  = 0;
    right = npts;
    while (left < right) begin
      mid = left + (right - left) / 2;
      if (pt_total[mid] > tint) right = mid;
      else left = mid + 1;
    end
    if (left == 0) begin
      cov        = sat_div({48'd0, sum_total, 16'd0}, sum_unique);
      r.coverage = cov[47:0];
      r.status   = ST_NOFILT;
      return r;
    end
    if (left >= npts) begin
      thr = {16'd0, pt_count[npts-1], 16'd0};
    end else begin
      dint = tint - pt_total[left-1];
      dc   = pt_count[left] - pt_count[left-1];
      num  = {48'd0, dint, tfrac} * {96'd0, dc};
      thr  = {16'd0, pt_count[left-1], 16'd0} +
             sat_div(num, pt_total[left] - pt_total[left-1]);
    end
    r.threshold_value = thr[47:0];
    if (interp_at(root_q(thr), lt, lu)) begin
      lt = 0;
      lu = 0;
      r.status = ST_NOLOW;
    end
    r.low_cut_total  = lt;
    r.low_cut_unique = lu;
    if (interp_at(thr, ht, hu)) begin
      r.status = ST_INSUFF;
      return r;
    end
    r.high_cut_total  = ht;
    r.high_cut_unique = hu;
    if (hu <= lu) begin
      r.status = ST_INSUFF;
      return r;
    end
    diff = (ht > lt) ? ht - lt : 0;
    cov  = sat_div({48'd0, diff, 16'd0}, hu - lu);
    r.coverage = (cov > 64'hFFFF_FFFF_FFFF) ? '1 : cov[47:0];
    return r;
  endfunction

  function automatic void histogram_clear();
    npts       = 0;
    sum_total  = 0;
    sum_unique = 0;
    last_cnt   = 33'h1_0000_0000;
    err_latch  = 0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      histogram_clear();
      cutoff = 16'd64881;
      coverage_q.delete();
    end else begin
      // result side first: a strobe always belongs to an earlier last row
      if (out_strobe) begin
        if (coverage_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result: %p", out_result);
        end else begin
          exp_res = coverage_q.pop_front();
          exp_f   = unpack_fields(exp_res);
          got_f   = unpack_fields(out_result);
          for (int i = 0; i < 9; i++) begin
            if (exp_f[i] !== got_f[i]) begin
              fail_count++;
              if (fail_count <= 10)
                $display("mismatch %s: expected %h, got %h", field_name[i], exp_f[i],
                         got_f[i]);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) cutoff = cfg_data;
      // row transfer
      if (start && !busy) begin
        row_absorb(in_row.row_count, in_row.row_frequency);
        if (in_row.last_row) begin
          coverage_q.push_back(coverage_predict());
          histogram_clear();
        end
      end
    end
    pending = coverage_q.size();
  end

endmodule

>>> bench/kmer_coverage_estimator_top_tb.sv
// Testbench top: clock, reset, histogram stimulus and the final verdict.
module kmer_coverage_estimator_top_tb;
  import kce_pkg::*;

  localparam int LIMIT = 5000000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  kce_in_t     in_row;
  logic        out_strobe;
  kce_out_t    out_result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  int          fail_count;
  int          pending;

  int          rows_sent;
  int          idle_pct;
  int          cycles;

  kmer_coverage_estimator_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_row     (in_row),
    .out_strobe (out_strobe),
    .out_result (out_result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  kce_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_row     (in_row),
    .out_strobe (out_strobe),
    .out_result (out_result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // one row transfer, with random idle cycles ahead of it
  task automatic send_row(input logic [31:0] cnt, input logic [31:0] freq, input bit last);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    in_row <= '{row_count: cnt, row_frequency: freq, last_row: last};
    @(posedge clk);
    while (busy) @(posedge clk);
    rows_sent++;
  endtask

  // stop sending until every result is in, then let the back end settle
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic cutoff_write(input logic [15:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // increasing counts with shaped frequencies; broken = one non-increasing step
  task automatic wellformed(input bit broken);
    int          n, bad;
    logic [31:0] c, f;
    n   = ($urandom_range(9) == 0) ? $urandom_range(30, 120) : $urandom_range(2, 12);
    bad = broken ? $urandom_range(1, n - 1) : -1;
    c   = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      f = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 1 << $urandom_range(0, 20));
      send_row(c, f, i == n - 1);
      if (i + 1 == bad) c = c - $urandom_range(0, 2);
      else if ($urandom_range(15) == 0) c = c + $urandom_range(1, 100000);
      else c = c + $urandom_range(1, 4);
    end
  endtask

  task automatic noise_rows();
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++)
      send_row($urandom, ($urandom_range(7) == 0) ? 0 : $urandom, i == n - 1);
  endtask

  // high counts and wide frequencies, mostly overflowing the running total
  task automatic big_rows();
    int          n;
    logic [31:0] c;
    n = $urandom_range(2, 4);
    c = 32'hF000_0000 + $urandom_range(0, 1000);
    for (int i = 0; i < n; i++) begin
      send_row(c, $urandom, i == n - 1);
      c = c + $urandom_range(1, 1 << 24);
    end
  endtask

  task automatic table_overrun();
    for (int i = 1; i <= 258; i++) send_row(i, 1, i == 258);
  endtask

  task automatic random_histogram();
    int k;
    k = $urandom_range(99);
    if (k < 75) wellformed(0);
    else if (k < 85) noise_rows();
    else if (k < 92) wellformed(1);
    else if (k < 96) big_rows();
    else send_row($urandom, $urandom, 1'b1);
  endtask

  int          phase_idle [5] = '{0, 62, 0, 62, 38};
  logic [15:0] cutoff_tab [5] = '{16'd65535, 16'd1, 16'd0, 16'd64881, 16'd0};
  int          target, base_idle;

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_row    = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    rows_sent = 0;
    idle_pct  = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: too few points
    send_row(5, 10, 1);
    // not increasing
    send_row(10, 5, 0);
    send_row(10, 3, 0);
    send_row(20, 1, 1);
    // running total wraps
    send_row(32'h8000_0000, 32'hFFFF_FFFF, 0);
    send_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    // zero rows skipped, then a normal histogram
    send_row(0, 7, 0);
    send_row(1, 0, 0);
    send_row(2, 100, 0);
    send_row(3, 50, 0);
    send_row(20, 400, 0);
    send_row(21, 400, 0);
    send_row(22, 300, 1);
    // first point dominates: no filtering
    send_row(1, 1000000, 0);
    send_row(2, 1, 1);

    // phases: register setting and sender idling change together
    for (int p = 0; p < 5; p++) begin
      drain();
      cutoff_write((p == 4) ? 16'($urandom_range(1, 65535)) : cutoff_tab[p]);
      target = rows_sent + 300;
      if (p == 3) begin
        idle_pct = 0;
        table_overrun();
      end
      while (rows_sent < target) begin
        // some histograms run with no idling at all
        base_idle = phase_idle[p];
        idle_pct  = ($urandom_range(3) == 0) ? 0 : base_idle;
        random_histogram();
      end
    end

    drain();
    if (fail_count == 0 && pending == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/kce_pkg.sv
hw/rtl/kce_divider.sv
hw/rtl/kce_front.sv
hw/rtl/kce_back.sv
hw/rtl/kce_fifo.sv
hw/rtl/kmer_coverage_estimator_top.sv
bench/kce_checker.sv
bench/kmer_coverage_estimator_top_tb.sv
